// ===== rtl/pps_pkg.sv =====
`default_nettype none

package pps_pkg;

	localparam int MAX_TASKS_DEF = 16;
	localparam int TIME_BITS_DEF = 16;

	localparam int ID_W    = 8;
	localparam int ARR_W   = 16;
	localparam int BURST_W = 12;
	localparam int PRIO_W  = 8;
	localparam int OUT_W   = 16;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_TICK  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	// Best candidate seen so far, handed from one cell to the next.
	typedef struct packed {
		logic               found;
		logic [PRIO_W-1:0]  prio;
		logic [ID_W-1:0]    id;
		logic [ARR_W-1:0]   arrival;
		logic [BURST_W-1:0] burst;
		logic [BURST_W-1:0] rem;
	} cand_t;

	// Task load broadcast to every cell.
	typedef struct packed {
		logic               we;
		logic [ID_W-1:0]    id;
		logic [ARR_W-1:0]   arrival;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
	} load_t;

endpackage

`default_nettype wire

// ===== rtl/preemptive_priority_scheduler.sv =====
// Preemptive priority scheduler with a table of up to MAX_TASKS tasks.
// Input channel (task_valid/task_ready) carries one command per transfer:
// load appends a task, tick runs the scheduler one time unit, clear empties
// the table and zeroes time. Only a tick produces a result on the output
// channel (res_valid/res_ready).
// A load or clear takes effect at its transfer and the block is ready again
// in the next cycle. A tick sends a search token down a row of MAX_TASKS
// cells, one cell per cycle, each cell keeping the better of its own task and
// the candidate handed in by its neighbor. The winner passes through the
// result stage into the output register, where res_valid rises; the input
// side stays busy until that result is written to the output register.
// Loads and clears are taken while a finished result waits at the output.
// If the receiver stalls, the result is held; a following tick completes its
// search and then waits until the output register is free.
// Reset clears the task count, completion count, time and all handshake
// state; table contents are undefined until loaded.
`default_nettype none

module preemptive_priority_scheduler
	import pps_pkg::*;
#(
	parameter int MAX_TASKS = MAX_TASKS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               task_valid,
	output logic               task_ready,
	input  logic [1:0]         mode,
	input  logic [ID_W-1:0]    task_id,
	input  logic [ARR_W-1:0]   arrival,
	input  logic [BURST_W-1:0] burst,
	input  logic [PRIO_W-1:0]  priority_req,
	output logic               res_valid,
	input  logic               res_ready,
	output logic               ran,
	output logic [3:0]         slot_run,
	output logic [ID_W-1:0]    id_run,
	output logic               finished,
	output logic [OUT_W-1:0]   completion_time,
	output logic [OUT_W-1:0]   turnaround,
	output logic [OUT_W-1:0]   waiting,
	output logic               all_done,
	output logic [OUT_W-1:0]   time_now
);

	localparam int CNT_W  = $clog2(MAX_TASKS + 1);
	localparam int SLOT_W = $clog2(MAX_TASKS);
	localparam int CMP_W  = (TIME_BITS > ARR_W) ? TIME_BITS : ARR_W;
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	state_t state_q, state_d;

	logic [CNT_W-1:0]     loaded_q;
	logic [CNT_W-1:0]     done_q;
	logic [TIME_BITS-1:0] time_q;
	logic [TIME_BITS-1:0] tnext_q;

	logic  xfer;
	logic  is_load, is_tick, is_clear;
	load_t ld;
	logic  fin_go;

	cand_t             chain_cand [MAX_TASKS+1];
	logic              chain_tok  [MAX_TASKS+1];
	logic [SLOT_W-1:0] chain_slot [MAX_TASKS+1];

	logic        end_tok;
	cand_t       best;
	logic [SLOT_W-1:0] best_slot;
	logic        dec_en;
	logic        done_now;

	// Result stage between the search and the output register.
	logic               ran_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic [ID_W-1:0]    id_s1;
	logic               fin_s1;
	logic [TIME_BITS-1:0] ct_s1;
	logic [CMP_W-1:0]   tat_s1;
	logic [BURST_W-1:0] burst_s1;

	logic [CMP_W-1:0] wait_val;

	logic               res_valid_q;
	logic               ran_q;
	logic [3:0]         slot_q;
	logic [ID_W-1:0]    id_q;
	logic               fin_q;
	logic [OUT_W-1:0]   ct_q;
	logic [OUT_W-1:0]   tat_q;
	logic [OUT_W-1:0]   wait_q;
	logic               all_done_q;
	logic [OUT_W-1:0]   time_now_q;

	assign xfer = task_valid && task_ready;

	always_comb begin
		is_load  = 1'b0;
		is_tick  = 1'b0;
		is_clear = 1'b0;
		case (mode)
			MODE_LOAD:  is_load  = 1'b1;
			MODE_TICK:  is_tick  = 1'b1;
			MODE_CLEAR: is_clear = 1'b1;
			default: ;
		endcase
	end

	assign ld.we = xfer && is_load && (burst != '0) && (loaded_q < CNT_W'(MAX_TASKS));
	assign ld.id      = task_id;
	assign ld.arrival = arrival;
	assign ld.burst   = burst;
	assign ld.prio    = priority_req;

	assign chain_cand[0] = '0;
	assign chain_tok[0]  = xfer && is_tick;
	assign chain_slot[0] = '0;

	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		pps_cell #(
			.IDX   (i),
			.CNT_W (CNT_W),
			.SLOT_W(SLOT_W),
			.TIME_W(TIME_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ld      (ld),
			.loaded  (loaded_q),
			.cur_time(time_q),
			.dec_en  (dec_en),
			.dec_slot(best_slot),
			.tok_in  (chain_tok[i]),
			.slot_in (chain_slot[i]),
			.cand_in (chain_cand[i]),
			.tok_q   (chain_tok[i+1]),
			.slot_q  (chain_slot[i+1]),
			.cand_q  (chain_cand[i+1])
		);
	end

	assign end_tok   = chain_tok[MAX_TASKS];
	assign best      = chain_cand[MAX_TASKS];
	assign best_slot = chain_slot[MAX_TASKS];
	assign dec_en    = end_tok && best.found;
	assign done_now  = dec_en && (best.rem == BURST_W'(1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (xfer && is_tick) state_d = ST_SCAN;
			ST_SCAN: if (end_tok) state_d = ST_FIN;
			ST_FIN:  if (!res_valid_q || res_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		task_ready = 1'b0;
		fin_go     = 1'b0;
		case (state_q)
			ST_IDLE: task_ready = 1'b1;
			ST_FIN:  fin_go     = !res_valid_q || res_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			loaded_q <= '0;
			done_q   <= '0;
			time_q   <= '0;
		end else begin
			state_q <= state_d;
			if (xfer && is_clear) begin
				loaded_q <= '0;
				done_q   <= '0;
				time_q   <= '0;
			end else begin
				if (ld.we) loaded_q <= loaded_q + CNT_W'(1);
				if (done_now) done_q <= done_q + CNT_W'(1);
				if (end_tok) time_q <= tnext_q;
			end
		end
	end

	// The saturated next time is ready before the search ends, so the
	// turnaround subtract needs no increment in front of it on the last step.
	always_ff @(posedge clk) begin
		if (xfer && is_tick) begin
			tnext_q <= (time_q == TIME_MAX) ? time_q : time_q + TIME_BITS'(1);
		end
		if (end_tok) begin
			ran_s1   <= best.found;
			slot_s1  <= best.found ? best_slot : '0;
			id_s1    <= best.found ? best.id : '0;
			fin_s1   <= done_now;
			ct_s1    <= tnext_q;
			tat_s1   <= CMP_W'(tnext_q) - CMP_W'(best.arrival);
			burst_s1 <= best.burst;
		end
	end

	assign wait_val = (tat_s1 >= CMP_W'(burst_s1)) ? tat_s1 - CMP_W'(burst_s1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fin_go) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			ran_q      <= ran_s1;
			slot_q     <= 4'(slot_s1);
			id_q       <= id_s1;
			fin_q      <= fin_s1;
			ct_q       <= fin_s1 ? OUT_W'(ct_s1) : '0;
			tat_q      <= fin_s1 ? OUT_W'(tat_s1) : '0;
			wait_q     <= fin_s1 ? OUT_W'(wait_val) : '0;
			all_done_q <= done_q == loaded_q;
			time_now_q <= OUT_W'(time_q);
		end
	end

	assign res_valid       = res_valid_q;
	assign ran             = ran_q;
	assign slot_run        = slot_q;
	assign id_run          = id_q;
	assign finished        = fin_q;
	assign completion_time = ct_q;
	assign turnaround      = tat_q;
	assign waiting         = wait_q;
	assign all_done        = all_done_q;
	assign time_now        = time_now_q;

endmodule

`default_nettype wire

// ===== rtl/pps_cell.sv =====
`default_nettype none

module pps_cell
	import pps_pkg::*;
#(
	parameter int IDX    = 0,
	parameter int CNT_W  = 5,
	parameter int SLOT_W = 4,
	parameter int TIME_W = TIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  load_t             ld,
	input  logic [CNT_W-1:0]  loaded,
	input  logic [TIME_W-1:0] cur_time,
	input  logic              dec_en,
	input  logic [SLOT_W-1:0] dec_slot,
	input  logic              tok_in,
	input  logic [SLOT_W-1:0] slot_in,
	input  cand_t             cand_in,
	output logic              tok_q,
	output logic [SLOT_W-1:0] slot_q,
	output cand_t             cand_q
);

	localparam int CMP_W = (TIME_W > ARR_W) ? TIME_W : ARR_W;

	logic [ID_W-1:0]    id_q;
	logic [ARR_W-1:0]   arrival_q;
	logic [BURST_W-1:0] burst_q;
	logic [PRIO_W-1:0]  prio_q;
	logic [BURST_W-1:0] rem_q;

	logic in_use;
	logic arrived;
	logic take;
	cand_t own;

	assign in_use  = CNT_W'(IDX) < loaded;
	assign arrived = CMP_W'(arrival_q) <= CMP_W'(cur_time);
	assign take    = in_use && arrived && (rem_q != '0)
		&& (!cand_in.found || (prio_q < cand_in.prio));

	assign own = '{found: 1'b1, prio: prio_q, id: id_q, arrival: arrival_q,
		burst: burst_q, rem: rem_q};

	always_ff @(posedge clk) begin
		if (ld.we && (loaded == CNT_W'(IDX))) begin
			id_q      <= ld.id;
			arrival_q <= ld.arrival;
			burst_q   <= ld.burst;
			prio_q    <= ld.prio;
			rem_q     <= ld.burst;
		end else if (dec_en && (dec_slot == SLOT_W'(IDX))) begin
			rem_q <= rem_q - BURST_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		cand_q <= take ? own : cand_in;
		slot_q <= take ? SLOT_W'(IDX) : slot_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pps_checker.sv =====
`default_nettype none

module pps_checker
	import pps_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               task_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic               ran,
	input logic [3:0]         slot_run,
	input logic [ID_W-1:0]    id_run,
	input logic               finished,
	input logic [OUT_W-1:0]   completion_time,
	input logic [OUT_W-1:0]   turnaround,
	input logic [OUT_W-1:0]   waiting,
	input logic               all_done,
	input logic [OUT_W-1:0]   time_now
);

	// A stalled result stays on the port until its transfer.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(time_now) && $stable(finished))
		else $error("result changed while stalled");

	// An idle tick reports nothing about any task.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !ran |-> !finished && slot_run == 4'd0 && id_run == '0
			&& completion_time == '0 && turnaround == '0 && waiting == '0)
		else $error("idle tick carries task data");

	// A completion belongs to a task that ran and happens at the current time.
	a_fin_time: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && finished |-> ran && completion_time == time_now)
		else $error("completion inconsistent with time");

	// A stalled result is not dropped while a tick is being searched.
	a_no_accept_early: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready && !task_ready |=> !$fell(res_valid))
		else $error("result dropped during a tick");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;
	import pps_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int NSLOT = MAX_TASKS_DEF;
	localparam int RAND_ITEMS = 550;
	localparam int CYCLE_LIMIT = 4000000;
	localparam logic [OUT_W-1:0] T_MAX = '1;

	typedef struct packed {
		logic               ran;
		logic [3:0]         slot;
		logic [ID_W-1:0]    id;
		logic               fin;
		logic [OUT_W-1:0]   ct;
		logic [OUT_W-1:0]   tat;
		logic [OUT_W-1:0]   wt;
		logic               all_done;
		logic [OUT_W-1:0]   tnow;
	} sched_res_t;

	typedef struct packed {
		logic [1:0]         md;
		logic [ID_W-1:0]    tid;
		logic [ARR_W-1:0]   arr;
		logic [BURST_W-1:0] bst;
		logic [PRIO_W-1:0]  prio;
		int                 rpt;
		logic               typed;
		sched_res_t         res;
	} cmd_row_t;

	logic               clk;
	logic               arst_n;
	logic               task_valid;
	logic               task_ready;
	logic [1:0]         mode;
	logic [ID_W-1:0]    task_id;
	logic [ARR_W-1:0]   arrival;
	logic [BURST_W-1:0] burst;
	logic [PRIO_W-1:0]  priority_req;
	logic               res_valid;
	logic               res_ready;
	logic               ran;
	logic [3:0]         slot_run;
	logic [ID_W-1:0]    id_run;
	logic               finished;
	logic [OUT_W-1:0]   completion_time;
	logic [OUT_W-1:0]   turnaround;
	logic [OUT_W-1:0]   waiting;
	logic               all_done;
	logic [OUT_W-1:0]   time_now;

	preemptive_priority_scheduler u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.task_valid      (task_valid),
		.task_ready      (task_ready),
		.mode            (mode),
		.task_id         (task_id),
		.arrival         (arrival),
		.burst           (burst),
		.priority_req    (priority_req),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.ran             (ran),
		.slot_run        (slot_run),
		.id_run          (id_run),
		.finished        (finished),
		.completion_time (completion_time),
		.turnaround      (turnaround),
		.waiting         (waiting),
		.all_done        (all_done),
		.time_now        (time_now)
	);

	// Scheduler shadow state.
	logic [ID_W-1:0]    tbl_id    [NSLOT];
	logic [ARR_W-1:0]   tbl_arr   [NSLOT];
	logic [BURST_W-1:0] tbl_burst [NSLOT];
	logic [PRIO_W-1:0]  tbl_prio  [NSLOT];
	logic [BURST_W-1:0] tbl_rem   [NSLOT];
	int                 n_loaded = 0;
	int                 n_done = 0;
	logic [OUT_W-1:0]   now_t = '0;

	sched_res_t pending_ticks [$];
	sched_res_t got_exp;
	cmd_row_t   dir_rows [$];

	int         n_err = 0;
	int         n_sent = 0;
	int         burst_left = 0;
	int         cyc = 0;
	int         pat_left = 0;
	logic       no_idle = 1'b0;
	logic [15:0] stall_pat = '1;

	function automatic cmd_row_t mk(input logic [1:0] md, input logic [ID_W-1:0] tid,
			input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] bst,
			input logic [PRIO_W-1:0] prio, input int rpt);
		cmd_row_t c;
		c = '0;
		c.md = md;
		c.tid = tid;
		c.arr = arr;
		c.bst = bst;
		c.prio = prio;
		c.rpt = rpt;
		return c;
	endfunction

	function automatic cmd_row_t mk_tick(input logic r, input logic [3:0] s,
			input logic [ID_W-1:0] id, input logic f, input logic [OUT_W-1:0] ct,
			input logic [OUT_W-1:0] tat, input logic [OUT_W-1:0] wt, input logic ad,
			input logic [OUT_W-1:0] tn);
		cmd_row_t c;
		c = mk(MODE_TICK, '0, '0, '0, '0, 1);
		c.typed = 1'b1;
		c.res = '{ran: r, slot: s, id: id, fin: f, ct: ct, tat: tat, wt: wt,
			all_done: ad, tnow: tn};
		return c;
	endfunction

	// One scheduling step: pick the eligible task with the lowest priority number,
	// lowest slot on ties, run it one unit and advance the saturating clock.
	function automatic sched_res_t sched_tick();
		sched_res_t r;
		logic found;
		int sel;
		logic [PRIO_W-1:0] best;
		logic [OUT_W-1:0] tat;
		r = '0;
		found = 1'b0;
		sel = 0;
		best = '0;
		for (int i = 0; i < n_loaded; i++) begin
			if (tbl_arr[i] <= now_t && tbl_rem[i] != 0) begin
				if (!found || tbl_prio[i] < best) begin
					found = 1'b1;
					best = tbl_prio[i];
					sel = i;
				end
			end
		end
		if (now_t != T_MAX)
			now_t = now_t + 1'b1;
		if (found) begin
			r.ran = 1'b1;
			r.slot = sel[3:0];
			r.id = tbl_id[sel];
			tbl_rem[sel] = tbl_rem[sel] - 1'b1;
			if (tbl_rem[sel] == 0) begin
				r.fin = 1'b1;
				n_done++;
				tat = now_t - tbl_arr[sel];
				r.ct = now_t;
				r.tat = tat;
				// A task that finishes after the clock saturated can show less
				// turnaround than its burst; waiting then floors at zero.
				r.wt = (tat >= {4'b0, tbl_burst[sel]}) ? tat - tbl_burst[sel] : '0;
			end
		end
		r.all_done = (n_done == n_loaded);
		r.tnow = now_t;
		return r;
	endfunction

	function automatic cmd_row_t rand_load();
		cmd_row_t c;
		logic [ARR_W:0] a;
		int p;
		c = mk(MODE_LOAD, ID_W'($urandom), ARR_W'($urandom), BURST_W'($urandom),
			PRIO_W'($urandom), 1);
		p = $urandom_range(0, 99);
		if (p < 70) begin
			a = {1'b0, now_t} + (ARR_W+1)'($urandom_range(0, 10));
			c.arr = a[ARR_W] ? '1 : a[ARR_W-1:0];
		end
		p = $urandom_range(0, 99);
		if (p < 85)
			c.bst = BURST_W'($urandom_range(1, 6));
		else if (p < 90)
			c.bst = '0;
		else
			c.bst = BURST_W'($urandom_range(0, 4095));
		if ($urandom_range(0, 1) == 0)
			c.prio = PRIO_W'($urandom_range(0, 3));
		return c;
	endfunction

	function automatic cmd_row_t rand_other(input logic [1:0] md);
		return mk(md, ID_W'($urandom), ARR_W'($urandom), BURST_W'($urandom),
			PRIO_W'($urandom), 1);
	endfunction

	task automatic send_cmd(input cmd_row_t c);
		int gap;
		sched_res_t r;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 10);
			if (gap > 0 && !no_idle) begin
				@(negedge clk);
				task_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		task_valid = 1'b1;
		mode = c.md;
		task_id = c.tid;
		arrival = c.arr;
		burst = c.bst;
		priority_req = c.prio;
		@(posedge clk);
		while (!task_ready) @(posedge clk);
		burst_left--;
		n_sent++;
		case (c.md)
			MODE_LOAD: begin
				if (n_loaded < NSLOT && c.bst != 0) begin
					tbl_id[n_loaded] = c.tid;
					tbl_arr[n_loaded] = c.arr;
					tbl_burst[n_loaded] = c.bst;
					tbl_prio[n_loaded] = c.prio;
					tbl_rem[n_loaded] = c.bst;
					n_loaded++;
				end
			end
			MODE_TICK: begin
				r = sched_tick();
				pending_ticks.push_back(c.typed ? c.res : r);
			end
			MODE_CLEAR: begin
				n_loaded = 0;
				n_done = 0;
				now_t = '0;
			end
			default: ;
		endcase
	endtask

	task automatic cmp_field(input string fname, input logic [OUT_W-1:0] e,
			input logic [OUT_W-1:0] g);
		if (e !== g) begin
			n_err++;
			if (n_err <= 10)
				$display("mismatch on %s: expected %0h, got %0h", fname, e, g);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver stalls follow a rotating pattern that is swapped now and then.
	always @(negedge clk) begin
		if (pat_left == 0) begin
			pat_left = $urandom_range(16, 80);
			case ($urandom_range(0, 3))
				0: stall_pat = '1;
				1: stall_pat = 16'($urandom) | 16'h0001;
				2: stall_pat = 16'($urandom | $urandom) | 16'h0001;
				default: stall_pat = 16'h0001;
			endcase
		end
		pat_left--;
		stall_pat = {stall_pat[0], stall_pat[15:1]};
		res_ready <= arst_n && (no_idle || stall_pat[0]);
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (pending_ticks.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("result transfer with no tick outstanding");
			end else begin
				got_exp = pending_ticks.pop_front();
				cmp_field("ran", OUT_W'(got_exp.ran), OUT_W'(ran));
				cmp_field("slot_run", OUT_W'(got_exp.slot), OUT_W'(slot_run));
				cmp_field("id_run", OUT_W'(got_exp.id), OUT_W'(id_run));
				cmp_field("finished", OUT_W'(got_exp.fin), OUT_W'(finished));
				cmp_field("completion_time", got_exp.ct, completion_time);
				cmp_field("turnaround", got_exp.tat, turnaround);
				cmp_field("waiting", got_exp.wt, waiting);
				cmp_field("all_done", OUT_W'(got_exp.all_done), OUT_W'(all_done));
				cmp_field("time_now", got_exp.tnow, time_now);
			end
		end
	end

	initial begin
		int n_ld;
		int n_tk;
		int p;
		arst_n = 1'b0;
		task_valid = 1'b0;
		mode = MODE_TICK;
		task_id = '0;
		arrival = '0;
		burst = '0;
		priority_req = '0;
		res_ready = 1'b0;

		// Empty table, reserved mode, extreme fields, zero burst.
		dir_rows.push_back(mk_tick(1'b0, 4'd0, 8'h00, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1,
			16'd1));
		dir_rows.push_back(mk(MODE_SPARE, '1, '1, '1, '1, 1));
		dir_rows.push_back(mk(MODE_LOAD, 8'hFF, 16'h0000, 12'h001, 8'hFF, 1));
		dir_rows.push_back(mk(MODE_LOAD, 8'h00, 16'hFFFF, 12'hFFF, 8'h00, 1));
		dir_rows.push_back(mk(MODE_LOAD, 8'h55, 16'h0000, 12'h000, 8'h00, 1));
		dir_rows.push_back(mk_tick(1'b1, 4'd0, 8'hFF, 1'b1, 16'd2, 16'd2, 16'd1, 1'b0,
			16'd2));
		dir_rows.push_back(mk_tick(1'b0, 4'd0, 8'h00, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0,
			16'd3));
		dir_rows.push_back(mk(MODE_CLEAR, '0, '0, '0, '0, 1));
		// Equal priorities resolve to the lower slot; a late urgent task preempts.
		dir_rows.push_back(mk(MODE_LOAD, 8'h0A, 16'd0, 12'd3, 8'd5, 1));
		dir_rows.push_back(mk(MODE_LOAD, 8'h0B, 16'd0, 12'd2, 8'd5, 1));
		dir_rows.push_back(mk(MODE_LOAD, 8'h0C, 16'd2, 12'd1, 8'd1, 1));
		dir_rows.push_back(mk_tick(1'b1, 4'd0, 8'h0A, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0,
			16'd1));
		dir_rows.push_back(mk(MODE_TICK, '0, '0, '0, '0, 6));
		dir_rows.push_back(mk(MODE_CLEAR, '0, '0, '0, '0, 1));
		// Seventeen loads: the last one finds the table full.
		dir_rows.push_back(mk(MODE_LOAD, 8'hA5, 16'd0, 12'd2, 8'h80, 17));
		dir_rows.push_back(mk(MODE_TICK, '0, '0, '0, '0, 33));
		dir_rows.push_back(mk(MODE_CLEAR, '0, '0, '0, '0, 1));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[k]) begin
			no_idle = dir_rows[k].rpt > 100;
			repeat (dir_rows[k].rpt) send_cmd(dir_rows[k]);
		end
		no_idle = 1'b0;

		n_sent = 0;
		while (n_sent < RAND_ITEMS) begin
			if ($urandom_range(0, 2) == 0)
				send_cmd(rand_other(MODE_CLEAR));
			n_ld = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 5);
			repeat (n_ld) send_cmd(rand_load());
			n_tk = $urandom_range(4, 40);
			repeat (n_tk) begin
				p = $urandom_range(0, 19);
				if (p == 0)
					send_cmd(rand_load());
				else if (p == 1)
					send_cmd(rand_other(MODE_SPARE));
				else
					send_cmd(rand_other(MODE_TICK));
			end
		end

		@(negedge clk);
		task_valid = 1'b0;
		while (pending_ticks.size() != 0) @(posedge clk);
		repeat (4 * NSLOT) @(posedge clk);
		if (n_err == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
